### hdl/assert_macros.svh
// Assertion macros used by the buffer pool frame manager.
// Each use is active in simulation and empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BP_ASSERT(lbl, prop, msg)
`define BP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/bplru_pkg.sv
// Shared types and constants for the LRU buffer pool frame manager.
// Used by bplru_cell and buffer_pool_lru_frame_manager.
`default_nettype none
package bplru_pkg;
  localparam int NUM_FRAMES_DEF   = 16;
  localparam int PAGE_ID_BITS_DEF = 32;
  localparam int PIN_BITS_DEF     = 8;
  localparam int MAX_IDX_BITS     = 6;
  localparam int MAX_PID_BITS     = 64;
  localparam int DPC_BITS         = 32;

  localparam logic [1:0] FUNC_FETCH = 2'd0;
  localparam logic [1:0] FUNC_UNPIN = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_ALL_PINNED = 3'd2;
  localparam logic [2:0] ST_UNPINNED   = 3'd3;
  localparam logic [2:0] ST_NOT_RES    = 3'd4;
  localparam logic [2:0] ST_FLUSH      = 3'd5;

  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_READ = 2'd1;
  localparam logic [1:0] FILL_ZERO = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_HIT, CMD_FILL, CMD_UNPIN, CMD_CLEAN
  } cmd_op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cmd_op_t                  op;
    logic [MAX_IDX_BITS-1:0]  idx;
    logic [MAX_IDX_BITS-1:0]  rank;   // old rank of the frame made most recent
    logic [MAX_PID_BITS-1:0]  pid;
    logic                     mark;
  } cell_cmd_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                     hit;
    logic [MAX_IDX_BITS-1:0]  hit_idx;
    logic                     vic;
    logic [MAX_IDX_BITS-1:0]  vic_idx;
    logic [MAX_IDX_BITS-1:0]  vic_rank;
  } chain_t;
endpackage
`default_nettype wire

### hdl/buffer_pool_lru_frame_manager.sv
// channel | dir | handshake              | payload
// s       | in  | s_tvalid/s_tready      | s_tuser=func, s_tdata=page_id,mark_dirty,dpc
// m       | out | m_tvalid/m_tready      | m_tdata=status..fill_kind, m_tlast=last
// Fetch and unpin: the hit/victim token walks the cell chain, one cell per cycle,
// then S_DECIDE applies the update and loads the result once the output is free.
// Flush visits one frame per cycle; a dirty frame holds it while the output stalls.
// Reset is synchronous; no clearing pass. Output stalls hold S_DECIDE, S_DONE and dirty frames in S_FLUSH.
// Top level of the LRU buffer pool frame manager; uses bplru_pkg, bplru_cell,
// and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module buffer_pool_lru_frame_manager import bplru_pkg::*; #(
  parameter int NUM_FRAMES   = NUM_FRAMES_DEF,
  parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
  parameter int PIN_BITS     = PIN_BITS_DEF,
  localparam int IW    = $clog2(NUM_FRAMES),
  localparam int IN_W  = ((PAGE_ID_BITS + 1 + DPC_BITS + 7) / 8) * 8,
  localparam int OUT_N = 3 + IW + 1 + PAGE_ID_BITS + 2,
  localparam int OUT_W = ((OUT_N + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // page_id, mark_dirty, disk_page_count, zero pad
  input  wire logic [1:0]       s_tuser,   // func
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // status, frame_index, writeback_valid,
                                           // writeback_page, fill_kind, zero pad
  output logic                  m_tlast
);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_FRAMES - 1);
  localparam int CW = (DPC_BITS > PAGE_ID_BITS) ? DPC_BITS : PAGE_ID_BITS;

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_DECIDE, S_FLUSH, S_DONE} state_t;

  state_t                  state;
  logic [IW-1:0]           cnt;
  logic [1:0]              func;
  logic [PAGE_ID_BITS-1:0] pid;
  logic                    mark;
  logic [DPC_BITS-1:0]     dpc;

  logic [2:0]              o_status;
  logic [IW-1:0]           o_frame;
  logic                    o_wbv;
  logic [PAGE_ID_BITS-1:0] o_wbp;
  logic [1:0]              o_fill;

  cell_cmd_t               cmd;
  chain_t                  chain [NUM_FRAMES+1];
  logic [NUM_FRAMES-1:0]   match_vec;
  logic [PAGE_ID_BITS-1:0] tag_a   [NUM_FRAMES];
  logic                    valid_a [NUM_FRAMES];
  logic                    dirty_a [NUM_FRAMES];
  logic [IW-1:0]           rank_a  [NUM_FRAMES];

  chain_t                  res;
  logic                    out_free;
  logic                    out_load;
  logic                    reserved;
  logic [IW-1:0]           sel;

  assign chain[0] = '0;
  assign res      = chain[NUM_FRAMES];
  assign out_free = !m_tvalid || m_tready;
  assign reserved = (pid == {PAGE_ID_BITS{1'b1}});
  assign s_tready = (state == S_IDLE);
  assign m_tdata  = OUT_W'({o_fill, o_wbp, o_wbv, o_frame, o_status});
  // a result register load this cycle
  assign out_load = out_free && ((state == S_DECIDE) || (state == S_DONE) ||
                    ((state == S_FLUSH) && valid_a[sel] && dirty_a[sel]));

  always_comb begin
    case (state)
      S_FLUSH: sel = cnt;
      default: sel = res.hit ? res.hit_idx[IW-1:0] : res.vic_idx[IW-1:0];
    endcase
  end

  for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
    bplru_cell #(
      .NUM_FRAMES(NUM_FRAMES), .PAGE_ID_BITS(PAGE_ID_BITS),
      .PIN_BITS(PIN_BITS), .IDX(k)
    ) u_cell (
      .clk, .rst, .cmd, .search_pid(pid),
      .chain_in(chain[k]), .chain_out(chain[k+1]),
      .match(match_vec[k]), .tag(tag_a[k]), .valid(valid_a[k]),
      .dirty(dirty_a[k]), .rank(rank_a[k])
    );
  end

  // cell update request for this cycle
  always_comb begin
    cmd      = '0;
    cmd.op   = CMD_NONE;
    cmd.idx  = MAX_IDX_BITS'(sel);
    cmd.rank = MAX_IDX_BITS'(rank_a[sel]);
    cmd.pid  = MAX_PID_BITS'(pid);
    cmd.mark = mark;
    case (state)
      S_DECIDE: begin
        if (out_free && !reserved) begin
          if (func == FUNC_FETCH) begin
            if (res.hit)      cmd.op = CMD_HIT;
            else if (res.vic) cmd.op = CMD_FILL;
          end else if (res.hit) begin
            cmd.op = CMD_UNPIN;
          end
        end
      end
      S_FLUSH: begin
        if (out_free && valid_a[sel] && dirty_a[sel]) cmd.op = CMD_CLEAN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func <= s_tuser;
            pid  <= s_tdata[PAGE_ID_BITS-1:0];
            mark <= s_tdata[PAGE_ID_BITS];
            dpc  <= s_tdata[PAGE_ID_BITS+1 +: DPC_BITS];
            cnt  <= '0;
            case (s_tuser)
              FUNC_FETCH, FUNC_UNPIN: state <= S_SEARCH;
              FUNC_FLUSH:             state <= S_FLUSH;
              default:                state <= S_IDLE;
            endcase
          end
        end
        S_SEARCH: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
            if (func == FUNC_FETCH && !reserved && res.hit) begin
              o_status <= ST_HIT;
              o_frame  <= sel;
              o_wbv    <= 1'b0;
              o_wbp    <= '0;
              o_fill   <= FILL_NONE;
            end else if (func == FUNC_FETCH && !reserved && res.vic) begin
              o_status <= ST_MISS;
              o_frame  <= sel;
              o_wbv    <= valid_a[sel] && dirty_a[sel];
              o_wbp    <= (valid_a[sel] && dirty_a[sel]) ? tag_a[sel] : '0;
              o_fill   <= (CW'(pid) < CW'(dpc)) ? FILL_READ : FILL_ZERO;
            end else if (func == FUNC_UNPIN && !reserved && res.hit) begin
              o_status <= ST_UNPINNED;
              o_frame  <= sel;
              o_wbv    <= 1'b0;
              o_wbp    <= '0;
              o_fill   <= FILL_NONE;
            end else begin
              o_status <= (func == FUNC_FETCH) ? ST_ALL_PINNED : ST_NOT_RES;
              o_frame  <= '0;
              o_wbv    <= 1'b0;
              o_wbp    <= '0;
              o_fill   <= FILL_NONE;
            end
          end
        end
        S_FLUSH: begin
          if (valid_a[sel] && dirty_a[sel]) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              m_tlast  <= 1'b0;
              o_status <= ST_FLUSH;
              o_frame  <= sel;
              o_wbv    <= 1'b1;
              o_wbp    <= tag_a[sel];
              o_fill   <= FILL_NONE;
              cnt      <= cnt + 1'b1;
              if (cnt == LAST_IDX) state <= S_DONE;
            end
          end else begin
            cnt <= cnt + 1'b1;
            if (cnt == LAST_IDX) state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tlast  <= 1'b1;
            o_status <= ST_FLUSH;
            o_frame  <= '0;
            o_wbv    <= 1'b0;
            o_wbp    <= '0;
            o_fill   <= FILL_NONE;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a page lives in at most one frame
  `BP_ASSERT(a_tag_unique, $onehot0(match_vec), "page resident in two frames")
  // no request is taken while the search token is in flight
  `BP_ASSERT(a_busy_search, state == S_SEARCH |-> !s_tready, "request taken during search")
  // a stalled result is neither dropped nor replaced
  `BP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule
`default_nettype wire

### hdl/bplru_cell.sv
// One frame of the buffer pool: tag, valid, pins, dirty and LRU rank.
// Registers the running hit/victim token for its right neighbor. Uses bplru_pkg.
`default_nettype none
module bplru_cell import bplru_pkg::*; #(
  parameter int NUM_FRAMES   = NUM_FRAMES_DEF,
  parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
  parameter int PIN_BITS     = PIN_BITS_DEF,
  parameter int IDX          = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cell_cmd_t                 cmd,
  input  wire logic [PAGE_ID_BITS-1:0]   search_pid,
  input  wire chain_t                    chain_in,
  output chain_t                         chain_out,
  output logic                           match,
  output logic [PAGE_ID_BITS-1:0]        tag,
  output logic                           valid,
  output logic                           dirty,
  output logic [$clog2(NUM_FRAMES)-1:0]  rank
);
  localparam int IW = $clog2(NUM_FRAMES);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  logic [PIN_BITS-1:0] pins;
  logic                me;
  logic                older;
  logic                take_vic;
  chain_t              chain_next;

  assign match = valid && (tag == search_pid);
  assign me    = (cmd.idx[IW-1:0] == MY_IDX);
  assign older = (rank < cmd.rank[IW-1:0]);
  assign take_vic = (pins == '0) &&
                    (!chain_in.vic || (MAX_IDX_BITS'(rank) > chain_in.vic_rank));

  always_comb begin
    chain_next = chain_in;
    if (match) begin
      chain_next.hit     = 1'b1;
      chain_next.hit_idx = MAX_IDX_BITS'(IDX);
    end
    if (take_vic) begin
      chain_next.vic      = 1'b1;
      chain_next.vic_idx  = MAX_IDX_BITS'(IDX);
      chain_next.vic_rank = MAX_IDX_BITS'(rank);
    end
  end

  always_ff @(posedge clk) begin
    chain_out <= chain_next;
    if (rst) begin
      valid <= 1'b0;
      pins  <= '0;
      dirty <= 1'b0;
      rank  <= MY_IDX;
    end else begin
      case (cmd.op)
        CMD_HIT, CMD_FILL: begin
          if (me) begin
            rank <= '0;
            if (cmd.op == CMD_FILL) begin
              tag   <= cmd.pid[PAGE_ID_BITS-1:0];
              valid <= 1'b1;
              pins  <= PIN_BITS'(1);
              dirty <= 1'b0;
            end else if (pins != PIN_MAX) begin
              pins <= pins + 1'b1;
            end
          end else if (older) begin
            rank <= rank + 1'b1;
          end
        end
        CMD_UNPIN: begin
          if (me) begin
            if (pins != '0) pins <= pins - 1'b1;
            if (cmd.mark) dirty <= 1'b1;
          end
        end
        CMD_CLEAN: begin
          if (me) dirty <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
